// ===== rtl/lswc_pkg.sv =====
// Shared types, constants and helpers for the line segment window clipper.
`timescale 1ns / 1ps
package lswc_pkg;
	localparam int CB = 12;
	localparam int FB = 16;
	localparam int MW = CB + 1;
	localparam int NB = 4;
	localparam int BITS_PER_STG = 4;
	localparam int DIV_STAGES = FB / BITS_PER_STG;
	localparam int LATENCY = DIV_STAGES + 4;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_LEFT   = 2'd0;
	localparam logic [IDX_W-1:0] REG_TOP    = 2'd1;
	localparam logic [IDX_W-1:0] REG_RIGHT  = 2'd2;
	localparam logic [IDX_W-1:0] REG_BOTTOM = 2'd3;

	localparam logic [CB-1:0] RST_LEFT   = CB'(0);
	localparam logic [CB-1:0] RST_TOP    = CB'(0);
	localparam logic [CB-1:0] RST_RIGHT  = CB'(639);
	localparam logic [CB-1:0] RST_BOTTOM = CB'(479);

	localparam logic [FB:0] ONE_Q = (FB+1)'(1) << FB;

	typedef struct packed {
		logic signed [CB-1:0] start_x;
		logic signed [CB-1:0] start_y;
		logic signed [CB-1:0] end_x;
		logic signed [CB-1:0] end_y;
	} seg_t;

	typedef struct packed {
		logic                 visible;
		logic signed [CB-1:0] clip_start_x;
		logic signed [CB-1:0] clip_start_y;
		logic signed [CB-1:0] clip_end_x;
		logic signed [CB-1:0] clip_end_y;
	} res_t;

	typedef struct packed {
		logic signed [CB-1:0] left;
		logic signed [CB-1:0] top;
		logic signed [CB-1:0] right;
		logic signed [CB-1:0] bottom;
	} win_t;

	typedef struct packed {
		logic          use_max;
		logic          use_min;
		logic          zero_t2;
		logic          rej;
		logic          ge;
		logic [MW-1:0] den;
		logic [MW-1:0] rem;
		logic [FB-1:0] quot;
	} bnd_t;

	typedef struct packed {
		logic                 vld;
		logic signed [CB-1:0] sx;
		logic signed [CB-1:0] sy;
		logic signed [CB:0]   dx;
		logic signed [CB:0]   dy;
		bnd_t [NB-1:0]        bnd;
	} pipe_t;

	function automatic logic [MW-1:0] mag(input logic signed [CB:0] v);
		mag = v[CB] ? MW'(-v) : MW'(v);
	endfunction
endpackage

// ===== rtl/line_segment_window_clipper_core.sv =====
// Top level of the Liang-Barsky line segment window clipper.
//  channel  ports                         handshake
//  input    start, busy, seg              taken when start && !busy
//  result   done, result                  valid for one cycle while done
//  config   cfg_we, cfg_idx, cfg_data     written when cfg_we
// One item per cycle; busy stays low.
// Registers from acceptance to done: setup, four divider stages,
// ratio select, multiply, sum.
// Reset clears the window to 0,0 .. 639,479 and empties the pipeline.
// The receiver cannot stall, so the pipeline always advances.
`timescale 1ns / 1ps
module line_segment_window_clipper_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  lswc_pkg::seg_t                seg,
	output logic                          done,
	output lswc_pkg::res_t                result,
	input  logic                          cfg_we,
	input  logic [lswc_pkg::IDX_W-1:0]    cfg_idx,
	input  logic [lswc_pkg::CB-1:0]       cfg_data
);
	import lswc_pkg::*;

	win_t win_q;
	pipe_t pipe_s1, pipe_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.left <= RST_LEFT;
			win_q.top <= RST_TOP;
			win_q.right <= RST_RIGHT;
			win_q.bottom <= RST_BOTTOM;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_LEFT: win_q.left <= cfg_data;
				REG_TOP: win_q.top <= cfg_data;
				REG_RIGHT: win_q.right <= cfg_data;
				REG_BOTTOM: win_q.bottom <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	lswc_setup u_setup (
		.clk(clk), .arst_n(arst_n), .take(start && !busy),
		.seg(seg), .win(win_q), .pipe_s1(pipe_s1)
	);

	lswc_divider u_div (
		.clk(clk), .arst_n(arst_n), .pipe_in(pipe_s1), .pipe_out(pipe_s5)
	);

	lswc_interp u_interp (
		.clk(clk), .arst_n(arst_n), .pipe_in(pipe_s5),
		.done(done), .result(result)
	);
endmodule

// ===== rtl/lswc_setup.sv =====
// Input stage: deltas, boundary magnitudes and boundary classes.
`timescale 1ns / 1ps
module lswc_setup (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  lswc_pkg::seg_t seg,
	input  lswc_pkg::win_t win,
	output lswc_pkg::pipe_t pipe_s1
);
	import lswc_pkg::*;

	pipe_t nxt;
	logic signed [CB:0] dx, dy, d;
	logic signed [CB:0] q [NB];
	logic [MW-1:0] qm, pm;
	logic pneg, ppos, qneg;

	always_comb begin
		dx = {seg.end_x[CB-1], seg.end_x} - {seg.start_x[CB-1], seg.start_x};
		dy = {seg.end_y[CB-1], seg.end_y} - {seg.start_y[CB-1], seg.start_y};
		q[0] = {seg.start_x[CB-1], seg.start_x} - {win.left[CB-1], win.left};
		q[1] = {win.right[CB-1], win.right} - {seg.start_x[CB-1], seg.start_x};
		q[2] = {seg.start_y[CB-1], seg.start_y} - {win.top[CB-1], win.top};
		q[3] = {win.bottom[CB-1], win.bottom} - {seg.start_y[CB-1], seg.start_y};
		nxt = '0;
		nxt.vld = take;
		nxt.sx = seg.start_x;
		nxt.sy = seg.start_y;
		nxt.dx = dx;
		nxt.dy = dy;
		for (int i = 0; i < NB; i++) begin
			d = (i < 2) ? dx : dy;
			pneg = (i % 2 == 0) ? (!d[CB] && d != '0) : d[CB];
			ppos = (i % 2 == 0) ? d[CB] : (!d[CB] && d != '0);
			qneg = q[i][CB];
			qm = mag(q[i]);
			pm = mag(d);
			nxt.bnd[i].use_max = pneg && qneg;
			nxt.bnd[i].use_min = ppos && !qneg;
			nxt.bnd[i].zero_t2 = ppos && qneg;
			nxt.bnd[i].rej = (d == '0) && qneg;
			nxt.bnd[i].ge = qm >= pm;
			nxt.bnd[i].den = pm;
			nxt.bnd[i].rem = qm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_s1 <= '0;
		end else begin
			pipe_s1 <= nxt;
		end
	end
endmodule

// ===== rtl/lswc_divider.sv =====
// Pipelined restoring dividers for the four boundary ratios.
`timescale 1ns / 1ps
module lswc_divider (
	input  logic            clk,
	input  logic            arst_n,
	input  lswc_pkg::pipe_t pipe_in,
	output lswc_pkg::pipe_t pipe_out
);
	import lswc_pkg::*;

	pipe_t div_s [DIV_STAGES+1];

	assign div_s[0] = pipe_in;
	assign pipe_out = div_s[DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stg
		pipe_t nxt;
		logic [MW:0] r2;
		logic bit_q;

		always_comb begin
			nxt = div_s[g];
			for (int i = 0; i < NB; i++) begin
				for (int k = 0; k < BITS_PER_STG; k++) begin
					r2 = {nxt.bnd[i].rem, 1'b0};
					bit_q = r2 >= {1'b0, nxt.bnd[i].den};
					if (bit_q) begin
						r2 = r2 - {1'b0, nxt.bnd[i].den};
					end
					nxt.bnd[i].rem = r2[MW-1:0];
					nxt.bnd[i].quot = {nxt.bnd[i].quot[FB-2:0], bit_q};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s[g+1] <= '0;
			end else begin
				div_s[g+1] <= nxt;
			end
		end
	end
endmodule

// ===== rtl/lswc_interp.sv =====
// Entry/exit selection, endpoint products and result register.
`timescale 1ns / 1ps
module lswc_interp (
	input  logic            clk,
	input  logic            arst_n,
	input  lswc_pkg::pipe_t pipe_in,
	output logic            done,
	output lswc_pkg::res_t  result
);
	import lswc_pkg::*;

	logic [FB:0] r, t1, t2;
	logic rej;

	logic                 vld_s6, vis_s6;
	logic signed [CB-1:0] sx_s6, sy_s6;
	logic signed [CB:0]   dx_s6, dy_s6;
	logic [FB:0]          t1_s6, t2_s6;

	logic                 vld_s7, vis_s7;
	logic signed [CB-1:0] sx_s7, sy_s7;
	logic                 nx_s7, ny_s7;
	logic [MW-1:0]        s1x_s7, s1y_s7, s2x_s7, s2y_s7;

	logic [MW+FB:0] p1x, p1y, p2x, p2y;
	logic [CB-1:0]  ax1, ay1, ax2, ay2;

	logic vld_s8;
	res_t res_s8;

	always_comb begin
		t1 = '0;
		t2 = ONE_Q;
		rej = 1'b0;
		for (int i = 0; i < NB; i++) begin
			r = pipe_in.bnd[i].ge ? ONE_Q : {1'b0, pipe_in.bnd[i].quot};
			if (pipe_in.bnd[i].rej) begin
				rej = 1'b1;
			end
			if (pipe_in.bnd[i].use_max && r > t1) begin
				t1 = r;
			end
			if (pipe_in.bnd[i].zero_t2) begin
				t2 = '0;
			end else if (pipe_in.bnd[i].use_min && r < t2) begin
				t2 = r;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= pipe_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		vis_s6 <= !rej && (t1 < t2);
		sx_s6 <= pipe_in.sx;
		sy_s6 <= pipe_in.sy;
		dx_s6 <= pipe_in.dx;
		dy_s6 <= pipe_in.dy;
		t1_s6 <= t1;
		t2_s6 <= t2;
	end

	assign p1x = mag(dx_s6) * t1_s6;
	assign p1y = mag(dy_s6) * t1_s6;
	assign p2x = mag(dx_s6) * t2_s6;
	assign p2y = mag(dy_s6) * t2_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		vis_s7 <= vis_s6;
		sx_s7 <= sx_s6;
		sy_s7 <= sy_s6;
		nx_s7 <= dx_s6[CB];
		ny_s7 <= dy_s6[CB];
		s1x_s7 <= p1x[FB +: MW];
		s1y_s7 <= p1y[FB +: MW];
		s2x_s7 <= p2x[FB +: MW];
		s2y_s7 <= p2y[FB +: MW];
	end

	always_comb begin
		ax1 = nx_s7 ? -s1x_s7[CB-1:0] : s1x_s7[CB-1:0];
		ay1 = ny_s7 ? -s1y_s7[CB-1:0] : s1y_s7[CB-1:0];
		ax2 = nx_s7 ? -s2x_s7[CB-1:0] : s2x_s7[CB-1:0];
		ay2 = ny_s7 ? -s2y_s7[CB-1:0] : s2y_s7[CB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
			res_s8 <= '0;
		end else begin
			vld_s8 <= vld_s7;
			if (vis_s7) begin
				res_s8.visible <= 1'b1;
				res_s8.clip_start_x <= sx_s7 + ax1;
				res_s8.clip_start_y <= sy_s7 + ay1;
				res_s8.clip_end_x <= sx_s7 + ax2;
				res_s8.clip_end_y <= sy_s7 + ay2;
			end else begin
				res_s8 <= '0;
			end
		end
	end

	assign done = vld_s8;
	assign result = res_s8;
endmodule

// ===== rtl/lswc_checker.sv =====
// Port-level checks for the clipper core, bound to the top level.
`timescale 1ns / 1ps
module lswc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input lswc_pkg::seg_t             seg,
	input logic                       done,
	input lswc_pkg::res_t             result
);
	import lswc_pkg::*;

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("item lost in pipeline");

	a_nolat: assert property (@(posedge clk) disable iff (!arst_n)
		(!(start && !busy)) |-> ##LATENCY !done)
		else $error("spurious result");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.visible) |-> (result.clip_start_x == '0 &&
		result.clip_start_y == '0 && result.clip_end_x == '0 &&
		result.clip_end_y == '0))
		else $error("hidden result not zeroed");

	a_point: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && seg.start_x == seg.end_x && seg.start_y == seg.end_y)
		|-> ##LATENCY (!result.visible || (result.clip_start_x == result.clip_end_x
		&& result.clip_start_y == result.clip_end_y)))
		else $error("point segment clipped to two points");
endmodule

bind line_segment_window_clipper_core lswc_checker u_lswc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .seg(seg),
	.done(done), .result(result)
);
